// ----- hdl/mpee_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpee_pkg
// Shared codes, constants and saturating helpers of the molecule pool step.
// ----------------------------------------------------------------------------
package mpee_pkg;

  localparam logic [1:0] REQ_REACT  = 2'd0;
  localparam logic [1:0] REQ_SUM    = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;
  localparam logic [1:0] REQ_REINIT = 2'd3;

  localparam logic [1:0] MODE_INTEG  = 2'd0;
  localparam logic [1:0] MODE_COPY   = 2'd1;
  localparam logic [1:0] MODE_SCALED = 2'd2;
  localparam logic [1:0] MODE_HOLD   = 2'd3;

  localparam logic [2:0] CFG_POOL_MODE     = 3'd0;
  localparam logic [2:0] CFG_SUM_CONNECTED = 3'd1;
  localparam logic [2:0] CFG_INITIAL_COUNT = 3'd2;
  localparam logic [2:0] CFG_VOLUME_SCALE  = 3'd3;
  localparam logic [2:0] CFG_STEP_DT       = 3'd4;

  localparam logic [62:0] MASK63    = {63{1'b1}};
  localparam logic [63:0] INT64_MAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] INT64_MIN = {1'b1, {63{1'b0}}};
  localparam logic [63:0] ONE_62    = 64'd1 << 62;
  localparam logic [4:0]  SERIES_TERMS = 5'd25;

  // a + (neg ? -mag : mag), clamped to the signed 64-bit range.
  function automatic logic [63:0] sat_apply(logic [63:0] a, logic neg, logic [63:0] mag);
    logic signed [65:0] m;
    logic signed [65:0] r;
    m = $signed({2'b00, mag});
    if (neg) m = -m;
    r = $signed({{2{a[63]}}, a}) + m;
    if (r > $signed({2'b00, INT64_MAX})) return INT64_MAX;
    else if (r < $signed({2'b11, INT64_MIN})) return INT64_MIN;
    else return r[63:0];
  endfunction

  // Unsigned 63-bit add that sticks at the top value.
  function automatic logic [62:0] sat_add63(logic [62:0] a, logic [62:0] b);
    logic [63:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[63] ? MASK63 : s[62:0];
  endfunction

endpackage
`default_nettype wire

// ----- hdl/molecule_pool_exp_euler_step.sv -----
`default_nettype none
// Reaction and sum items finish in idle; reinit and ticks in modes 1 and 3 go straight to output.
// Plain Euler ticks and scaled-sum ticks take one pass of the multiplier. Exponential Euler
// ticks grow with i = integer part of B*dt/n and are ruled by the bit-serial divider, which
// runs 52 times (two 25-term series, two quotients) unless the decay factor underflows.
// Throughput: one item at a time; in_stall is high until the item is finished.
// Reset: synchronous, active low; control registers return to reset values, working ones have none.
// ----------------------------------------------------------------------------
// molecule_pool_exp_euler_step
// Molecule pool count integrator with a shared multiplier and a shared divider.
// ----------------------------------------------------------------------------
module molecule_pool_exp_euler_step import mpee_pkg::*; #(
  parameter int FRAC_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [62:0] in_rate_a,
  input  wire logic [62:0] in_rate_b,
  input  wire logic signed [63:0] in_total_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [63:0] out_pool_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  localparam logic [63:0] ONE_Q    = 64'd1 << FRAC_BITS;
  localparam logic [63:0] DT_RESET = ONE_Q / 64'd1000;
  localparam int          SH_C     = 62 - FRAC_BITS;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_OUT    = 4'd1;
  localparam logic [3:0] ST_M2_MUL = 4'd2;
  localparam logic [3:0] ST_EU_MUL = 4'd3;
  localparam logic [3:0] ST_X_MUL  = 4'd4;
  localparam logic [3:0] ST_X_DIV  = 4'd5;
  localparam logic [3:0] ST_S_MUL  = 4'd6;
  localparam logic [3:0] ST_S_DIV  = 4'd7;
  localparam logic [3:0] ST_P_MUL  = 4'd8;
  localparam logic [3:0] ST_T1_MUL = 4'd9;
  localparam logic [3:0] ST_Q_MUL  = 4'd10;
  localparam logic [3:0] ST_T2_MUL = 4'd11;
  localparam logic [3:0] ST_T2_DIV = 4'd12;

  // Product shifted down by the fraction width, sticking at all ones on overflow.
  function automatic logic [63:0] shr_frac_sat(logic [127:0] v);
    if (v[127:64+FRAC_BITS] != '0) return '1;
    else return v[63+FRAC_BITS:FRAC_BITS];
  endfunction

  logic [3:0]  state_r, state_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic        sumc_r, sumc_nxt;
  logic [62:0] init_r, init_nxt;
  logic [62:0] vol_r, vol_nxt;
  logic [62:0] dt_r, dt_nxt;
  logic [63:0] count_r, count_nxt;
  logic [62:0] prod_r, prod_nxt;
  logic [62:0] loss_r, loss_nxt;
  logic [63:0] suma_r, suma_nxt;
  logic        neg_r, neg_nxt;
  logic [5:0]  ip_r, ip_nxt;
  logic [5:0]  j_r, j_nxt;
  logic [4:0]  k_r, k_nxt;
  logic        phase_r, phase_nxt;
  logic [63:0] f_r, f_nxt;
  logic [63:0] t_r, t_nxt;
  logic [63:0] s_r, s_nxt;
  logic [63:0] c_r, c_nxt;
  logic [63:0] e1_r, e1_nxt;
  logic [63:0] t1_r, t1_nxt;
  logic [63:0] mul_a_r, mul_a_nxt;
  logic [63:0] mul_b_r, mul_b_nxt;
  logic        mul_start_r, mul_start_nxt;
  logic [127:0] div_n_r, div_n_nxt;
  logic [63:0] div_d_r, div_d_nxt;
  logic        div_start_r, div_start_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_count_r, out_count_nxt;

  logic         mul_done;
  logic [127:0] mul_p;
  logic         div_done;
  logic [63:0]  div_q;
  logic         in_xfer;
  logic [63:0]  tot_mag;
  logic [63:0]  s_new;
  logic [63:0]  c_new;
  logic [63:0]  diff;

  mpee_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start_r),
    .a(mul_a_r), .b(mul_b_r), .done(mul_done), .p(mul_p)
  );

  mpee_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start_r),
    .n(div_n_r), .d(div_d_r), .done(div_done), .q(div_q)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign tot_mag   = in_total_in[63] ? (~in_total_in + 64'd1) : in_total_in;
  assign s_new     = k_r[0] ? (s_r - div_q) : (s_r + div_q);
  assign c_new     = mul_p[125:62];
  assign diff      = (loss_r > prod_r) ? {1'b0, loss_r - prod_r} : {1'b0, prod_r - loss_r};

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    sumc_nxt      = sumc_r;
    init_nxt      = init_r;
    vol_nxt       = vol_r;
    dt_nxt        = dt_r;
    count_nxt     = count_r;
    prod_nxt      = prod_r;
    loss_nxt      = loss_r;
    suma_nxt      = suma_r;
    neg_nxt       = neg_r;
    ip_nxt        = ip_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    phase_nxt     = phase_r;
    f_nxt         = f_r;
    t_nxt         = t_r;
    s_nxt         = s_r;
    c_nxt         = c_r;
    e1_nxt        = e1_r;
    t1_nxt        = t1_r;
    mul_a_nxt     = mul_a_r;
    mul_b_nxt     = mul_b_r;
    mul_start_nxt = 1'b0;
    div_n_nxt     = div_n_r;
    div_d_nxt     = div_d_r;
    div_start_nxt = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_count_nxt = out_count_r;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_POOL_MODE:     mode_nxt = cfg_data[1:0];
        CFG_SUM_CONNECTED: sumc_nxt = cfg_data[0];
        CFG_INITIAL_COUNT: init_nxt = cfg_data[62:0];
        CFG_VOLUME_SCALE:  vol_nxt  = cfg_data[62:0];
        CFG_STEP_DT:       dt_nxt   = cfg_data[62:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (in_req_type)
            REQ_REACT: begin
              prod_nxt = sat_add63(prod_r, in_rate_a);
              loss_nxt = sat_add63(loss_r, in_rate_b);
            end
            REQ_SUM: suma_nxt = sat_apply(suma_r, in_total_in[63], tot_mag);
            REQ_TICK: begin
              unique case (mode_r)
                MODE_INTEG: begin
                  mul_start_nxt = 1'b1;
                  if (!count_r[63] && count_r != 64'd0 && loss_r != 63'd0) begin
                    mul_a_nxt = {1'b0, loss_r};
                    mul_b_nxt = {1'b0, dt_r};
                    state_nxt = ST_X_MUL;
                  end else begin
                    neg_nxt   = loss_r > prod_r;
                    mul_a_nxt = diff;
                    mul_b_nxt = {1'b0, dt_r};
                    state_nxt = ST_EU_MUL;
                  end
                end
                MODE_COPY: begin
                  count_nxt = suma_r;
                  suma_nxt  = 64'd0;
                  state_nxt = ST_OUT;
                end
                MODE_SCALED: begin
                  neg_nxt       = suma_r[63];
                  mul_a_nxt     = suma_r[63] ? (~suma_r + 64'd1) : suma_r;
                  mul_b_nxt     = {1'b0, vol_r};
                  mul_start_nxt = 1'b1;
                  state_nxt     = ST_M2_MUL;
                end
                MODE_HOLD: begin
                  count_nxt = {1'b0, init_r};
                  state_nxt = ST_OUT;
                end
                default: ;
              endcase
            end
            REQ_REINIT: begin
              prod_nxt  = 63'd0;
              loss_nxt  = 63'd0;
              suma_nxt  = 64'd0;
              count_nxt = {1'b0, init_r};
              if (mode_r == MODE_INTEG && sumc_r) mode_nxt = MODE_COPY;
              else if (mode_r == MODE_COPY && !sumc_r) mode_nxt = MODE_INTEG;
              state_nxt = ST_OUT;
            end
            default: ;
          endcase
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = count_r;
          state_nxt     = ST_IDLE;
        end
      end
      ST_M2_MUL: begin
        if (mul_done) begin
          count_nxt = sat_apply(64'd0, neg_r, shr_frac_sat(mul_p));
          suma_nxt  = 64'd0;
          state_nxt = ST_OUT;
        end
      end
      ST_EU_MUL: begin
        if (mul_done) begin
          count_nxt = sat_apply(count_r, neg_r, shr_frac_sat(mul_p));
          prod_nxt  = 63'd0;
          loss_nxt  = 63'd0;
          state_nxt = ST_OUT;
        end
      end
      ST_X_MUL: begin
        if (mul_done) begin
          div_n_nxt     = mul_p;
          div_d_nxt     = count_r;
          div_start_nxt = 1'b1;
          state_nxt     = ST_X_DIV;
        end
      end
      ST_X_DIV: begin
        if (div_done) begin
          mul_start_nxt = 1'b1;
          if (div_q[63:FRAC_BITS+6] != '0) begin
            // The decay factor underflows to zero.
            c_nxt     = 64'd0;
            mul_a_nxt = count_r;
            mul_b_nxt = 64'd0;
            state_nxt = ST_T1_MUL;
          end else begin
            ip_nxt    = div_q[FRAC_BITS+5:FRAC_BITS];
            f_nxt     = {2'b00, div_q[FRAC_BITS-1:0], {SH_C{1'b0}}};
            t_nxt     = ONE_62;
            s_nxt     = ONE_62;
            k_nxt     = 5'd1;
            phase_nxt = 1'b0;
            mul_a_nxt = ONE_62;
            mul_b_nxt = {2'b00, div_q[FRAC_BITS-1:0], {SH_C{1'b0}}};
            state_nxt = ST_S_MUL;
          end
        end
      end
      ST_S_MUL: begin
        if (mul_done) begin
          div_n_nxt     = {64'd0, c_new};
          div_d_nxt     = {59'd0, k_r};
          div_start_nxt = 1'b1;
          state_nxt     = ST_S_DIV;
        end
      end
      ST_S_DIV: begin
        if (div_done) begin
          mul_start_nxt = 1'b1;
          if (k_r == SERIES_TERMS) begin
            if (!phase_r) begin
              // Fraction factor done; next comes the factor exp(-1).
              c_nxt     = s_new;
              phase_nxt = 1'b1;
              f_nxt     = ONE_62;
              t_nxt     = ONE_62;
              s_nxt     = ONE_62;
              k_nxt     = 5'd1;
              mul_a_nxt = ONE_62;
              mul_b_nxt = ONE_62;
              state_nxt = ST_S_MUL;
            end else begin
              e1_nxt = s_new;
              j_nxt  = 6'd0;
              if (ip_r == 6'd0) begin
                mul_a_nxt = count_r;
                mul_b_nxt = c_r >> SH_C;
                state_nxt = ST_T1_MUL;
              end else begin
                mul_a_nxt = c_r;
                mul_b_nxt = s_new;
                state_nxt = ST_P_MUL;
              end
            end
          end else begin
            t_nxt     = div_q;
            s_nxt     = s_new;
            k_nxt     = k_r + 5'd1;
            mul_a_nxt = div_q;
            mul_b_nxt = f_r;
            state_nxt = ST_S_MUL;
          end
        end
      end
      ST_P_MUL: begin
        if (mul_done) begin
          c_nxt         = c_new;
          j_nxt         = j_r + 6'd1;
          mul_start_nxt = 1'b1;
          if (j_r + 6'd1 == ip_r) begin
            mul_a_nxt = count_r;
            mul_b_nxt = c_new >> SH_C;
            state_nxt = ST_T1_MUL;
          end else begin
            mul_a_nxt = c_new;
            mul_b_nxt = e1_r;
          end
        end
      end
      ST_T1_MUL: begin
        if (mul_done) begin
          t1_nxt        = shr_frac_sat(mul_p);
          mul_a_nxt     = count_r;
          mul_b_nxt     = ONE_Q - (c_r >> SH_C);
          mul_start_nxt = 1'b1;
          state_nxt     = ST_Q_MUL;
        end
      end
      ST_Q_MUL: begin
        if (mul_done) begin
          mul_a_nxt     = {1'b0, prod_r};
          mul_b_nxt     = shr_frac_sat(mul_p);
          mul_start_nxt = 1'b1;
          state_nxt     = ST_T2_MUL;
        end
      end
      ST_T2_MUL: begin
        if (mul_done) begin
          div_n_nxt     = mul_p;
          div_d_nxt     = {1'b0, loss_r};
          div_start_nxt = 1'b1;
          state_nxt     = ST_T2_DIV;
        end
      end
      ST_T2_DIV: begin
        if (div_done) begin
          count_nxt = sat_apply(t1_r, 1'b0, div_q);
          prod_nxt  = 63'd0;
          loss_nxt  = 63'd0;
          state_nxt = ST_OUT;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_INTEG;
      sumc_r      <= 1'b0;
      init_r      <= 63'd0;
      vol_r       <= ONE_Q[62:0];
      dt_r        <= DT_RESET[62:0];
      count_r     <= 64'd0;
      prod_r      <= 63'd0;
      loss_r      <= 63'd0;
      suma_r      <= 64'd0;
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= 5'd1;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      sumc_r      <= sumc_nxt;
      init_r      <= init_nxt;
      vol_r       <= vol_nxt;
      dt_r        <= dt_nxt;
      count_r     <= count_nxt;
      prod_r      <= prod_nxt;
      loss_r      <= loss_nxt;
      suma_r      <= suma_nxt;
      mul_start_r <= mul_start_nxt;
      div_start_r <= div_start_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
    end
  end

  // Working registers of the sequencer carry no reset.
  always_ff @(posedge clk) begin
    neg_r       <= neg_nxt;
    ip_r        <= ip_nxt;
    j_r         <= j_nxt;
    phase_r     <= phase_nxt;
    f_r         <= f_nxt;
    t_r         <= t_nxt;
    s_r         <= s_nxt;
    c_r         <= c_nxt;
    e1_r        <= e1_nxt;
    t1_r        <= t1_nxt;
    mul_a_r     <= mul_a_nxt;
    mul_b_r     <= mul_b_nxt;
    div_n_r     <= div_n_nxt;
    div_d_r     <= div_d_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_pool_count = out_count_r;

  // The two shared units are never launched together.
  assert property (@(posedge clk) disable iff (!rst_n) !(mul_start_r && div_start_r))
    else $error("multiplier and divider launched in the same cycle");

  // A unit is launched only while a tick is being worked on.
  assert property (@(posedge clk) disable iff (!rst_n)
    (mul_start_r || div_start_r) |-> (state_r != ST_IDLE && state_r != ST_OUT))
    else $error("arithmetic unit launched outside a tick");

  // Reaction and sum transfers leave the sequencer in idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_req_type == REQ_REACT || in_req_type == REQ_SUM)) |=> state_r == ST_IDLE)
    else $error("accumulate item did not finish in one cycle");

  // The series term index stays within the series.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_S_MUL || state_r == ST_S_DIV) |-> (k_r >= 5'd1 && k_r <= SERIES_TERMS))
    else $error("series term index out of range");

endmodule
`default_nettype wire

// ----- hdl/mpee_mul.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpee_mul
// 64 x 64 unsigned multiplier built from one 32 x 32 multiplier over four steps.
// ----------------------------------------------------------------------------
module mpee_mul import mpee_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [63:0]  a,
  input  wire logic [63:0]  b,
  output logic              done,
  output logic [127:0]      p
);

  logic [2:0]   step_r;
  logic         busy_r;
  logic         done_r;
  logic [63:0]  pp_r;
  logic [1:0]   sel_r;
  logic [127:0] acc_r;
  logic [31:0]  a_h;
  logic [31:0]  b_h;
  logic [1:0]   pos;

  assign a_h = step_r[1] ? a[63:32] : a[31:0];
  assign b_h = step_r[0] ? b[63:32] : b[31:0];
  assign pos = {1'b0, sel_r[1]} + {1'b0, sel_r[0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 3'd0;
        acc_r  <= '0;
      end else if (busy_r) begin
        if (step_r != 3'd4) begin
          pp_r  <= a_h * b_h;
          sel_r <= step_r[1:0];
        end
        if (step_r != 3'd0) acc_r <= acc_r + ({64'd0, pp_r} << {pos, 5'd0});
        if (step_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        step_r <= step_r + 3'd1;
      end
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule
`default_nettype wire

// ----- hdl/mpee_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpee_div
// 128 / 64 restoring divider, one quotient bit a cycle, saturating quotient.
// ----------------------------------------------------------------------------
module mpee_div import mpee_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [127:0] n,
  input  wire logic [63:0]  d,
  output logic              done,
  output logic [63:0]       q
);

  logic [63:0] r_r;
  logic [63:0] lo_r;
  logic [63:0] q_r;
  logic [63:0] d_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [64:0] rs;
  logic        ge;
  logic [63:0] rn;

  assign rs = {r_r, lo_r[63]};
  assign ge = rs[64] || (rs[63:0] >= d_r);
  assign rn = ge ? (rs[63:0] - d_r) : rs[63:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        d_r <= d;
        if (d == 64'd0 || n[127:64] >= d) begin
          // Quotient would not fit: it sticks at all ones.
          q_r    <= '1;
          done_r <= 1'b1;
        end else begin
          r_r    <= n[127:64];
          lo_r   <= n[63:0];
          cnt_r  <= 6'd0;
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        r_r   <= rn;
        lo_r  <= {lo_r[62:0], 1'b0};
        q_r   <= {q_r[62:0], ge};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule
`default_nettype wire
